>>> hw/rtl/pump_mode_hysteresis_controller_assert.svh
// Assertion macros for the pump mode controller.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef PUMP_MODE_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define PUMP_MODE_HYSTERESIS_CONTROLLER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PMHC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PMHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pmhc_pkg.sv
// Package for the pump mode controller: timing constants, control source
// codes, register indexes and the request payload type. No dependencies.
package pmhc_pkg;

   localparam int unsigned STARTUP_DELAY_MS  = 6000;
   localparam int unsigned HEARTBEAT_MS      = 5000;
   localparam int unsigned MS_PER_SECOND     = 1000;
   localparam int unsigned CENTI_PER_PERCENT = 100;

   localparam int unsigned DAY_W = 9;
   localparam logic [DAY_W-1:0] DAY_NONE = '1;

   // Window length in ms fits 26 bits: 65535 * 1000 < 2**26
   localparam int unsigned WIN_LEN_W = 26;

   typedef enum logic [2:0] {
      SRC_SCHEDULE = 3'd0,
      SRC_MANUAL   = 3'd1,
      SRC_DISARMED = 3'd2,
      SRC_WAIT     = 3'd3,
      SRC_AUTO     = 3'd4
   } src_type;

   typedef enum logic [2:0] {
      CSR_MANUAL_MODE   = 3'd0,
      CSR_AUTO_ARMED    = 3'd1,
      CSR_THRESHOLD     = 3'd2,
      CSR_HYSTERESIS    = 3'd3,
      CSR_SCHED_ENABLE  = 3'd4,
      CSR_SCHED_HOUR    = 3'd5,
      CSR_SCHED_MINUTE  = 3'd6,
      CSR_SCHED_SECONDS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0]      now_ms;
      logic             clock_valid;
      logic [4:0]       hour_of_day;
      logic [5:0]       minute_of_hour;
      logic [DAY_W-1:0] day_of_year;
      logic [13:0]      moisture_centi;
      logic             moisture_ready;
      logic             override_on;
      logic             manual_pump;
   } req_item_type;

endpackage

>>> hw/rtl/pump_mode_hysteresis_controller.sv
// Pump mode controller: daily schedule window, manual control and automatic
// moisture control with hysteresis. Uses pmhc_pkg and the assertion macros.
//
// One request is taken every clock cycle unless req_stall holds it off. A
// request lands in the input register, the whole control decision is made
// from it there and written to the result register together with the
// updated controller state when the request advances, so the next request
// sees the state the previous one left. The response register lets a new
// request in while a response waits to be taken; the block stalls requests
// only when both registers are full and the waiting response is held off.
// The user must write registers through the csr port only while no request
// is in flight; the block does not enforce this.
module pump_mode_hysteresis_controller import pmhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic        req_clock_valid,
   input  logic [4:0]  req_hour_of_day,
   input  logic [5:0]  req_minute_of_hour,
   input  logic [8:0]  req_day_of_year,
   input  logic [13:0] req_moisture_centi,
   input  logic        req_moisture_ready,
   input  logic        req_override_on,
   input  logic        req_manual_pump,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pump_drive,
   output logic [2:0]  rsp_control_source,
   output logic        rsp_window_active,
   output logic        rsp_report_now,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // Configuration
   logic                 manual_mode_ff;
   logic                 auto_armed_ff;
   logic [6:0]           threshold_ff;
   logic [6:0]           hysteresis_ff;
   logic                 sched_enable_ff;
   logic [4:0]           sched_hour_ff;
   logic [5:0]           sched_minute_ff;
   logic [WIN_LEN_W-1:0] win_len_ms_ff;

   // Controller state
   logic             window_running_ff, window_running_in;
   logic [31:0]      window_end_ff, window_end_in;
   logic [DAY_W-1:0] last_day_ff, last_day_in;
   logic             day_seen_ff, day_seen_in;
   logic             pump_state_ff, pump_state_in;
   logic             last_rep_state_ff, last_rep_state_in;
   logic [31:0]      last_rep_ms_ff, last_rep_ms_in;

   // Input and result registers
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_pump_ff;
   src_type      rsp_src_ff;
   logic         rsp_window_ff;
   logic         rsp_report_ff;

   logic         accept;
   logic         advance;

   logic         win_expired;
   logic         win_kept;
   logic         win_start;
   logic         win_run;
   logic [13:0]  moist_lo;
   logic [14:0]  moist_hi;
   logic         target;
   src_type      src;
   logic         report;

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.now_ms         <= req_now_ms;
         s1_item_ff.clock_valid    <= req_clock_valid;
         s1_item_ff.hour_of_day    <= req_hour_of_day;
         s1_item_ff.minute_of_hour <= req_minute_of_hour;
         s1_item_ff.day_of_year    <= req_day_of_year;
         s1_item_ff.moisture_centi <= req_moisture_centi;
         s1_item_ff.moisture_ready <= req_moisture_ready;
         s1_item_ff.override_on    <= req_override_on;
         s1_item_ff.manual_pump    <= req_manual_pump;
      end
   end

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_mode_ff  <= 1'b0;
         auto_armed_ff   <= 1'b0;
         threshold_ff    <= '0;
         hysteresis_ff   <= '0;
         sched_enable_ff <= 1'b0;
         sched_hour_ff   <= '0;
         sched_minute_ff <= '0;
         win_len_ms_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_MANUAL_MODE:   manual_mode_ff  <= csr_wdata[0];
            CSR_AUTO_ARMED:    auto_armed_ff   <= csr_wdata[0];
            CSR_THRESHOLD:     threshold_ff    <= csr_wdata[6:0];
            CSR_HYSTERESIS:    hysteresis_ff   <= csr_wdata[6:0];
            CSR_SCHED_ENABLE:  sched_enable_ff <= csr_wdata[0];
            CSR_SCHED_HOUR:    sched_hour_ff   <= csr_wdata[4:0];
            CSR_SCHED_MINUTE:  sched_minute_ff <= csr_wdata[5:0];
            // keep the window length in ms so the tick path needs only an add
            CSR_SCHED_SECONDS: win_len_ms_ff   <=
               WIN_LEN_W'({10'd0, csr_wdata} * WIN_LEN_W'(MS_PER_SECOND));
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Control decision for the request in the input register
   // ---------------------------------------------------------------
   assign win_expired = window_running_ff && (s1_item_ff.now_ms >= window_end_ff);
   assign win_kept    = window_running_ff && !win_expired;
   assign win_start   = sched_enable_ff && s1_item_ff.clock_valid && !win_kept &&
                        (s1_item_ff.hour_of_day == sched_hour_ff) &&
                        (s1_item_ff.minute_of_hour == sched_minute_ff) &&
                        (!day_seen_ff || (s1_item_ff.day_of_year != last_day_ff));
   assign win_run     = win_kept || win_start;

   assign moist_lo = 14'({7'd0, threshold_ff} * 14'(CENTI_PER_PERCENT));
   assign moist_hi = 15'(({8'd0, threshold_ff} + {8'd0, hysteresis_ff}) *
                         15'(CENTI_PER_PERCENT));

   always_comb begin
      if (win_run) begin
         target = 1'b1;
         src    = SRC_SCHEDULE;
      end else if (manual_mode_ff || s1_item_ff.override_on) begin
         target = s1_item_ff.manual_pump;
         src    = SRC_MANUAL;
      end else if (!auto_armed_ff) begin
         target = 1'b0;
         src    = SRC_DISARMED;
      end else if (!s1_item_ff.moisture_ready ||
                   (s1_item_ff.now_ms < 32'(STARTUP_DELAY_MS))) begin
         target = 1'b0;
         src    = SRC_WAIT;
      end else begin
         src = SRC_AUTO;
         if (s1_item_ff.moisture_centi < moist_lo) begin
            target = 1'b1;
         end else if ({1'b0, s1_item_ff.moisture_centi} > moist_hi) begin
            target = 1'b0;
         end else begin
            target = pump_state_ff;
         end
      end
   end

   // heartbeat distance is taken modulo 2**32
   assign report = (target != last_rep_state_ff) ||
                   ((s1_item_ff.now_ms - last_rep_ms_ff) > 32'(HEARTBEAT_MS));

   always_comb begin
      window_running_in = window_running_ff;
      window_end_in     = window_end_ff;
      last_day_in       = last_day_ff;
      day_seen_in       = day_seen_ff;
      pump_state_in     = pump_state_ff;
      last_rep_state_in = last_rep_state_ff;
      last_rep_ms_in    = last_rep_ms_ff;
      if (advance) begin
         window_running_in = win_run;
         pump_state_in     = target;
         if (win_start) begin
            window_end_in = s1_item_ff.now_ms + {{(32-WIN_LEN_W){1'b0}}, win_len_ms_ff};
            last_day_in   = s1_item_ff.day_of_year;
            day_seen_in   = 1'b1;
         end
         if (report) begin
            last_rep_state_in = target;
            last_rep_ms_in    = s1_item_ff.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_running_ff <= 1'b0;
         window_end_ff     <= '0;
         last_day_ff       <= DAY_NONE;
         day_seen_ff       <= 1'b0;
         pump_state_ff     <= 1'b0;
         last_rep_state_ff <= 1'b0;
         last_rep_ms_ff    <= '0;
      end else begin
         window_running_ff <= window_running_in;
         window_end_ff     <= window_end_in;
         last_day_ff       <= last_day_in;
         day_seen_ff       <= day_seen_in;
         pump_state_ff     <= pump_state_in;
         last_rep_state_ff <= last_rep_state_in;
         last_rep_ms_ff    <= last_rep_ms_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pump_ff   <= target;
         rsp_src_ff    <= src;
         rsp_window_ff <= win_run;
         rsp_report_ff <= report;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pump_drive     = rsp_pump_ff;
   assign rsp_control_source = rsp_src_ff;
   assign rsp_window_active  = rsp_window_ff;
   assign rsp_report_now     = rsp_report_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`include "pump_mode_hysteresis_controller_assert.svh"

   `PMHC_ASSERT_SAME(a_window_needs_day, window_running_ff, day_seen_ff, "window running without a recorded day")
   `PMHC_ASSERT_SAME(a_window_drives_pump, rsp_valid_ff && rsp_window_ff, rsp_pump_ff && (rsp_src_ff == SRC_SCHEDULE), "window response not from schedule")
   `PMHC_ASSERT_SAME(a_idle_src_pump_off, rsp_valid_ff && ((rsp_src_ff == SRC_DISARMED) || (rsp_src_ff == SRC_WAIT)), !rsp_pump_ff, "pump on while disarmed or waiting")
   `PMHC_ASSERT_NEXT(a_change_reported, advance && (target != last_rep_state_ff), rsp_valid_ff && rsp_report_ff, "output change not reported")
   `PMHC_ASSERT_SAME(a_no_stall_when_empty, !s1_valid_ff, !req_stall, "request stalled with empty input register")

endmodule
